// File: src/fnu_pkg.sv
// Package for the fuzzy norm unit: field widths, stream widths, family and command codes.
// Depends on nothing; imported by fnu_div_pipe, fuzzy_norm_unit and tb_fuzzy_norm_unit.
`default_nettype none

package fnu_pkg;

    // Default number of fraction bits in a grade (one = 2^FRAC_BITS)
    localparam int FNU_FRAC_BITS_DEF = 16;

    // Fixed field widths
    localparam int GRADE_W = 17;
    localparam int CMD_W   = 2;
    localparam int FAM_W   = 3;

    // Stream widths, padded to whole bytes
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 24;

    // Operator family held in the configuration register
    typedef enum logic [FAM_W-1:0] {
        FAM_ZADEH     = 3'd0,
        FAM_HAMACHER  = 3'd1,
        FAM_ALGEBRAIC = 3'd2,
        FAM_EINSTEIN  = 3'd3,
        FAM_BOUNDED   = 3'd4,
        FAM_DRASTIC   = 3'd5
    } family_t;

    // Per-item command
    typedef enum logic [CMD_W-1:0] {
        CMD_TNORM      = 2'd0,
        CMD_SNORM      = 2'd1,
        CMD_COMPLEMENT = 2'd2
    } cmd_t;

endpackage : fnu_pkg

`default_nettype wire

// File: src/fnu_div_pipe.sv
// Pipelined fractional divider for the fuzzy norm unit: one quotient bit per stage,
// then a select stage that picks the quotient or the precomputed direct result.
// Depends on fnu_pkg.
`default_nettype none

module fnu_div_pipe #(
    parameter int FRAC_BITS = fnu_pkg::FNU_FRAC_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   in_use_div,
    input  wire logic [FRAC_BITS+1:0]   in_rem,
    input  wire logic [FRAC_BITS+1:0]   in_den,
    input  wire logic [FRAC_BITS:0]     in_direct,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [FRAC_BITS:0]          out_result
);
    import fnu_pkg::*;

    localparam int DW = FRAC_BITS + 2;
    localparam int RW = FRAC_BITS + 1;
    localparam int NS = FRAC_BITS;

    logic              v_reg   [NS+1];
    logic              en      [NS+1];
    logic [DW-1:0]     rem_reg [NS];
    logic [DW-1:0]     den_reg [NS];
    logic [NS-1:0]     q_reg   [NS];
    logic [RW-1:0]     dir_reg [NS];
    logic              use_reg [NS];
    logic [RW-1:0]     res_reg;

    assign in_ready = en[0];

    // One restoring division step per stage
    for (genvar j = 0; j < NS; j++) begin : g_step
        logic          src_valid;
        logic          src_use;
        logic [DW-1:0] src_rem;
        logic [DW-1:0] src_den;
        logic [NS-1:0] src_q;
        logic [RW-1:0] src_dir;
        logic [DW:0]   r2;
        logic [DW:0]   diff;
        logic          ge;
        logic [DW-1:0] rem_next;
        logic [NS-1:0] q_next;

        if (j == 0) begin : g_first
            assign src_valid = in_valid;
            assign src_use   = in_use_div;
            assign src_rem   = in_rem;
            assign src_den   = in_den;
            assign src_q     = '0;
            assign src_dir   = in_direct;
        end
        else begin : g_rest
            assign src_valid = v_reg[j-1];
            assign src_use   = use_reg[j-1];
            assign src_rem   = rem_reg[j-1];
            assign src_den   = den_reg[j-1];
            assign src_q     = q_reg[j-1];
            assign src_dir   = dir_reg[j-1];
        end

        // Shift remainder, subtract divisor where it fits
        assign r2       = {src_rem, 1'b0};
        assign diff     = r2 - {1'b0, src_den};
        assign ge       = (r2 >= {1'b0, src_den});
        assign rem_next = ge ? diff[DW-1:0] : r2[DW-1:0];
        assign q_next   = {src_q[NS-2:0], ge};

        // Advance when empty or when the next stage advances
        assign en[j] = !v_reg[j] || en[j+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j] <= 1'b0;
            end
            else if (en[j])
            begin
                v_reg[j] <= src_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[j] && src_valid)
            begin
                rem_reg[j] <= rem_next;
                den_reg[j] <= src_den;
                q_reg[j]   <= q_next;
                dir_reg[j] <= src_dir;
                use_reg[j] <= src_use;
            end
        end
    end

    // Select stage: quotient or direct result
    assign en[NS] = !v_reg[NS] || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[NS] <= 1'b0;
        end
        else if (en[NS])
        begin
            v_reg[NS] <= v_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NS] && v_reg[NS-1])
        begin
            res_reg <= use_reg[NS-1] ? {1'b0, q_reg[NS-1]} : dir_reg[NS-1];
        end
    end

    assign out_valid  = v_reg[NS];
    assign out_result = res_reg;

endmodule : fnu_div_pipe

`default_nettype wire

// File: src/fuzzy_norm_unit.sv
// Fuzzy t-norm / s-norm / complement unit, top level.
// Throughput one item per cycle while the result side does not stall (m_axis_tready high).
// Stages: clamp, multiply, decode, then one divider stage per fraction bit and a select stage.
// The fractional divider sets the depth; a full pipeline holds FRAC_BITS + 4 items.
// Reset (rst_n, asynchronous, active low) empties the pipeline and sets the family to Zadeh.
// Depends on fnu_pkg and fnu_div_pipe.
`default_nettype none

module fuzzy_norm_unit #(
    parameter int FRAC_BITS = fnu_pkg::FNU_FRAC_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // Configuration write: norm_family
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [fnu_pkg::FAM_W-1:0]      cfg_data,
    // Input items
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [16:0] grade_a, [33:17] grade_b, [39:34] zero
    input  wire logic [fnu_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] cmd
    input  wire logic [fnu_pkg::CMD_W-1:0]      s_axis_tuser,
    // Result items
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [16:0] grade_out, [23:17] zero
    output logic [fnu_pkg::M_TDATA_W-1:0]       m_axis_tdata
);
    import fnu_pkg::*;

    localparam int MW = (FRAC_BITS > GRADE_W) ? FRAC_BITS : GRADE_W;
    localparam int NW = MW + 3;
    localparam int DW = FRAC_BITS + 2;
    localparam int RW = FRAC_BITS + 1;
    localparam logic signed [NW-1:0] ONE_S = {{(NW-1){1'b0}}, 1'b1} << FRAC_BITS;

    // Configuration register, always ready
    logic [FAM_W-1:0] fam_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fam_reg <= FAM_ZADEH;
        end
        else if (cfg_valid)
        begin
            fam_reg <= cfg_data;
        end
    end

    // Pipeline flow control
    logic en1, en2, en3;
    logic v1_reg, v2_reg, v3_reg;
    logic div_in_ready;

    assign en3           = !v3_reg || div_in_ready;
    assign en2           = !v2_reg || en3;
    assign en1           = !v1_reg || en2;
    assign s_axis_tready = en1;

    // Stage 1: clamp grades to one
    logic [GRADE_W-1:0] a_in, b_in;
    logic [NW-1:0]      a_w, b_w, a_c, b_c;
    logic [GRADE_W-1:0] a1_reg, b1_reg;
    logic [CMD_W-1:0]   cmd1_reg;
    logic [FAM_W-1:0]   fam1_reg;

    assign a_in = s_axis_tdata[GRADE_W-1:0];
    assign b_in = s_axis_tdata[2*GRADE_W-1:GRADE_W];
    assign a_w  = NW'(a_in);
    assign b_w  = NW'(b_in);
    assign a_c  = (a_w > ONE_S) ? ONE_S : a_w;
    assign b_c  = (b_w > ONE_S) ? ONE_S : b_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en1)
        begin
            v1_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && s_axis_tvalid)
        begin
            a1_reg   <= a_c[GRADE_W-1:0];
            b1_reg   <= b_c[GRADE_W-1:0];
            cmd1_reg <= s_axis_tuser;
            fam1_reg <= fam_reg;
        end
    end

    // Stage 2: truncated product
    logic [2*GRADE_W-1:0] prod;
    logic [2*GRADE_W-1:0] prod_sh;
    logic [GRADE_W-1:0]   a2_reg, b2_reg, p2_reg;
    logic [CMD_W-1:0]     cmd2_reg;
    logic [FAM_W-1:0]     fam2_reg;

    assign prod    = a1_reg * b1_reg;
    assign prod_sh = prod >> FRAC_BITS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en2)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2 && v1_reg)
        begin
            a2_reg   <= a1_reg;
            b2_reg   <= b1_reg;
            p2_reg   <= prod_sh[GRADE_W-1:0];
            cmd2_reg <= cmd1_reg;
            fam2_reg <= fam1_reg;
        end
    end

    // Stage 3: decode the operator into a direct result or a division
    logic signed [NW-1:0] a_s, b_s, p_s, sum_s;
    logic signed [NW-1:0] num_s, den_s, val_s, dir_s;
    logic                 req;
    logic                 use_next;
    logic [NW-1:0]        rem_w, den_w, dir_w;
    logic                 use3_reg;
    logic [DW-1:0]        rem3_reg, den3_reg;
    logic [RW-1:0]        dir3_reg;

    assign a_s   = $signed(NW'(a2_reg));
    assign b_s   = $signed(NW'(b2_reg));
    assign p_s   = $signed(NW'(p2_reg));
    assign sum_s = a_s + b_s;

    always_comb
    begin
        req   = 1'b0;
        num_s = '0;
        den_s = ONE_S;
        val_s = '0;
        case (cmd2_reg)
            CMD_TNORM:
            begin
                case (fam2_reg)
                    FAM_HAMACHER:
                    begin
                        if ((sum_s - p_s) <= 0)
                        begin
                            val_s = '0;
                        end
                        else
                        begin
                            req   = 1'b1;
                            num_s = p_s;
                            den_s = sum_s - p_s;
                        end
                    end
                    FAM_ALGEBRAIC:
                    begin
                        val_s = p_s;
                    end
                    FAM_EINSTEIN:
                    begin
                        req   = 1'b1;
                        num_s = p_s;
                        den_s = (ONE_S <<< 1) - (sum_s - p_s);
                    end
                    FAM_BOUNDED:
                    begin
                        val_s = ((sum_s - ONE_S) < 0) ? '0 : (sum_s - ONE_S);
                    end
                    FAM_DRASTIC:
                    begin
                        if ((a_s < ONE_S) && (b_s < ONE_S))
                        begin
                            val_s = '0;
                        end
                        else
                        begin
                            val_s = (a_s < b_s) ? a_s : b_s;
                        end
                    end
                    default:
                    begin
                        val_s = (a_s < b_s) ? a_s : b_s;
                    end
                endcase
            end
            CMD_SNORM:
            begin
                case (fam2_reg)
                    FAM_HAMACHER:
                    begin
                        if ((ONE_S - p_s) <= 0)
                        begin
                            val_s = ONE_S;
                        end
                        else
                        begin
                            req   = 1'b1;
                            num_s = sum_s - (p_s <<< 1);
                            den_s = ONE_S - p_s;
                        end
                    end
                    FAM_ALGEBRAIC:
                    begin
                        val_s = sum_s - p_s;
                    end
                    FAM_EINSTEIN:
                    begin
                        req   = 1'b1;
                        num_s = sum_s;
                        den_s = ONE_S + p_s;
                    end
                    FAM_BOUNDED:
                    begin
                        val_s = (sum_s > ONE_S) ? ONE_S : sum_s;
                    end
                    FAM_DRASTIC:
                    begin
                        if ((a_s > 0) && (b_s > 0))
                        begin
                            val_s = ONE_S;
                        end
                        else
                        begin
                            val_s = (a_s > b_s) ? a_s : b_s;
                        end
                    end
                    default:
                    begin
                        val_s = (a_s > b_s) ? a_s : b_s;
                    end
                endcase
            end
            CMD_COMPLEMENT:
            begin
                val_s = ONE_S - a_s;
            end
            default:
            begin
                val_s = '0;
            end
        endcase
    end

    // Resolve trivial quotients (a quotient of one or more clamps to one); clamp direct values to zero..one
    always_comb
    begin
        use_next = 1'b0;
        dir_s    = '0;
        if (req)
        begin
            if (num_s <= 0)
            begin
                dir_s = '0;
            end
            else if (den_s <= 0)
            begin
                dir_s = ONE_S;
            end
            else if (num_s >= den_s)
            begin
                dir_s = ONE_S;
            end
            else
            begin
                use_next = 1'b1;
            end
        end
        else if (val_s < 0)
        begin
            dir_s = '0;
        end
        else if (val_s > ONE_S)
        begin
            dir_s = ONE_S;
        end
        else
        begin
            dir_s = val_s;
        end
    end

    assign rem_w = num_s;
    assign den_w = den_s;
    assign dir_w = dir_s;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en3)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3 && v2_reg)
        begin
            use3_reg <= use_next;
            rem3_reg <= rem_w[DW-1:0];
            den3_reg <= den_w[DW-1:0];
            dir3_reg <= dir_w[RW-1:0];
        end
    end

    // Divider and select stages
    logic [RW-1:0]         div_result;
    logic [RW+GRADE_W-1:0] res_ext;

    fnu_div_pipe #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (v3_reg),
        .in_ready   (div_in_ready),
        .in_use_div (use3_reg),
        .in_rem     (rem3_reg),
        .in_den     (den3_reg),
        .in_direct  (dir3_reg),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (div_result)
    );

    // Fit the result to the 17-bit output field
    assign res_ext      = {{GRADE_W{1'b0}}, div_result};
    assign m_axis_tdata = {{(M_TDATA_W-GRADE_W){1'b0}}, res_ext[GRADE_W-1:0]};

endmodule : fuzzy_norm_unit

`default_nettype wire

// File: tb/sv/tb_fuzzy_norm_unit.sv
// Self-checking testbench for fuzzy_norm_unit: directed and random grade pairs under every family.
// Predicts each grade_out in a small scoreboard class and compares results in order.
// Depends on fnu_pkg and the fuzzy_norm_unit RTL.
`default_nettype none

module tb_fuzzy_norm_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import fnu_pkg::*;

    localparam int      FRAC          = FNU_FRAC_BITS_DEF;
    localparam longint  UNIT          = 64'd1 << FRAC;
    localparam int      ITEMS_PER_SET = 95;
    localparam int      NUM_SETS      = 10;
    localparam int      SETTLE_CYCLES = FNU_FRAC_BITS_DEF + 8;
    localparam int      QUIET_LIMIT   = 2000;

    // Codes the block must tolerate but the package does not name
    localparam logic [FAM_W-1:0] FAM_SPARE_6 = 3'd6;
    localparam logic [FAM_W-1:0] FAM_SPARE_7 = 3'd7;
    localparam logic [CMD_W-1:0] CMD_SPARE   = 2'd3;

    // Expected grades in arrival order, with its own copy of the family register
    class grade_scoreboard;
        logic [GRADE_W-1:0] pending[$];
        logic [FAM_W-1:0]   fam;
        int                 errors;

        function new();
            fam    = FAM_ZADEH;
            errors = 0;
        endfunction

        // truncated num/den in grade units; zero or negative numerator gives zero
        function longint unit_quot(longint num, longint den);
            if (num <= 0) return 0;
            if (den <= 0) return UNIT;
            return (num << FRAC) / den;
        endfunction

        function logic [GRADE_W-1:0] predict_grade(logic [CMD_W-1:0] c,
                                                   logic [GRADE_W-1:0] ga,
                                                   logic [GRADE_W-1:0] gb);
            longint a, b, p, r;
            a = (ga > UNIT) ? UNIT : longint'(ga);
            b = (gb > UNIT) ? UNIT : longint'(gb);
            p = (a * b) >> FRAC;
            case (c)
                CMD_TNORM:
                    case (fam)
                        FAM_HAMACHER:  r = (a + b - p <= 0) ? 0 : unit_quot(p, a + b - p);
                        FAM_ALGEBRAIC: r = p;
                        FAM_EINSTEIN:  r = unit_quot(p, 2 * UNIT - (a + b - p));
                        FAM_BOUNDED:   r = (a + b - UNIT > 0) ? a + b - UNIT : 0;
                        FAM_DRASTIC:   r = (a < UNIT && b < UNIT) ? 0 : ((a < b) ? a : b);
                        default:       r = (a < b) ? a : b;
                    endcase
                CMD_SNORM:
                    case (fam)
                        FAM_HAMACHER:  r = (UNIT - p <= 0) ? UNIT
                                                           : unit_quot(a + b - 2 * p, UNIT - p);
                        FAM_ALGEBRAIC: r = a + b - p;
                        FAM_EINSTEIN:  r = unit_quot(a + b, UNIT + p);
                        FAM_BOUNDED:   r = (a + b < UNIT) ? a + b : UNIT;
                        FAM_DRASTIC:   r = (a > 0 && b > 0) ? UNIT : ((a > b) ? a : b);
                        default:       r = (a > b) ? a : b;
                    endcase
                CMD_COMPLEMENT: r = UNIT - a;
                default:        r = 0;
            endcase
            if (r < 0) r = 0;
            else if (r > UNIT) r = UNIT;
            return r[GRADE_W-1:0];
        endfunction

        function void note_input(logic [CMD_W-1:0] c, logic [GRADE_W-1:0] ga,
                                 logic [GRADE_W-1:0] gb);
            pending.push_back(predict_grade(c, ga, gb));
        endfunction

        function void check_result(logic [GRADE_W-1:0] got);
            logic [GRADE_W-1:0] want;
            if (pending.size() == 0)
            begin
                $display("%0t grade_out wrong: expected none, actual %0d", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                $display("%0t grade_out wrong: expected %0d, actual %0d", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [FAM_W-1:0]       cfg_data      = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic [CMD_W-1:0]       s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;

    grade_scoreboard sb = new();

    int tx_gap_pct   = 0;
    int rx_stall_pct = 0;
    int stall_left   = 0;
    int quiet_cycles = 0;

    fuzzy_norm_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 clk = ~clk;

    // Observe handshakes at the rising edge: note inputs, check results, track the register
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.fam = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                sb.note_input(s_axis_tuser, s_axis_tdata[GRADE_W-1:0],
                              s_axis_tdata[2*GRADE_W-1:GRADE_W]);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata[GRADE_W-1:0]);
        end
    end

    // Stall the result side in random bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if (rx_stall_pct > 0 && $urandom_range(1, 100) <= rx_stall_pct)
        begin
            stall_left = $urandom_range(1, 8) - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Abort when no item has moved on any channel for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t watchdog: no item moved for %0d cycles", $time, QUIET_LIMIT);
            $display("fuzzy_norm_unit: mismatch");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offer one item from a falling edge and hold it until taken; returns at a falling edge
    task automatic send_item(input logic [CMD_W-1:0] c, input logic [GRADE_W-1:0] ga,
                             input logic [GRADE_W-1:0] gb);
        int gap;
        if (tx_gap_pct > 0 && $urandom_range(1, 100) <= tx_gap_pct)
        begin
            gap = $urandom_range(1, 8);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W - 2*GRADE_W){1'b0}}, gb, ga};
        s_axis_tuser  <= c;
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
    endtask

    // Drop valid and wait until every expected grade has come back, then let the pipe settle
    task automatic wait_all_graded();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write the family register while the block is idle
    task automatic set_family(input logic [FAM_W-1:0] f);
        wait_all_graded();
        cfg_valid <= 1'b1;
        cfg_data  <= f;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Weighted grade: edges, over-range codes and plain values
    function automatic logic [GRADE_W-1:0] pick_grade();
        case ($urandom_range(0, 19))
            0, 1:    return '0;
            2, 3:    return GRADE_W'(UNIT);
            4:       return GRADE_W'($urandom_range(UNIT + 1, (1 << GRADE_W) - 1));
            5:       return GRADE_W'(1);
            6:       return GRADE_W'(UNIT - 1);
            default: return GRADE_W'($urandom_range(0, UNIT));
        endcase
    endfunction

    initial
    begin
        logic [FAM_W-1:0] set_family_code[NUM_SETS];
        logic [CMD_W-1:0] c;

        set_family_code = '{FAM_ZADEH, FAM_HAMACHER, FAM_ALGEBRAIC, FAM_EINSTEIN,
                            FAM_BOUNDED, FAM_DRASTIC, FAM_SPARE_6, FAM_SPARE_7,
                            FAM_HAMACHER, FAM_EINSTEIN};

        // Hold reset, then release it on a falling edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        tx_gap_pct   = 20;
        rx_stall_pct = 20;

        // Directed: reset family is Zadeh; extremes, over-range grades, unused command
        send_item(CMD_TNORM, 17'd0, 17'd65536);
        send_item(CMD_SNORM, 17'd65536, 17'd0);
        send_item(CMD_COMPLEMENT, 17'd0, 17'd131071);
        send_item(CMD_COMPLEMENT, 17'd65536, 17'd0);
        send_item(CMD_SPARE, 17'd131071, 17'd131071);
        send_item(CMD_TNORM, 17'd131071, 17'd40000);

        // Hamacher: both 0/0 corners and ordinary values
        set_family(FAM_HAMACHER);
        send_item(CMD_TNORM, 17'd0, 17'd0);
        send_item(CMD_SNORM, 17'd65536, 17'd65536);
        send_item(CMD_TNORM, 17'd32768, 17'd32768);
        send_item(CMD_SNORM, 17'd32768, 17'd98304);

        set_family(FAM_ALGEBRAIC);
        send_item(CMD_TNORM, 17'd65536, 17'd65536);
        send_item(CMD_SNORM, 17'd131071, 17'd0);

        set_family(FAM_EINSTEIN);
        send_item(CMD_TNORM, 17'd65535, 17'd65535);
        send_item(CMD_SNORM, 17'd65536, 17'd65536);
        send_item(CMD_SNORM, 17'd1, 17'd1);

        set_family(FAM_BOUNDED);
        send_item(CMD_TNORM, 17'd30000, 17'd20000);
        send_item(CMD_SNORM, 17'd50000, 17'd50000);

        // Drastic: one operand at one, both just below one, tiny and zero operands
        set_family(FAM_DRASTIC);
        send_item(CMD_TNORM, 17'd65536, 17'd12345);
        send_item(CMD_TNORM, 17'd65535, 17'd65535);
        send_item(CMD_SNORM, 17'd1, 17'd1);
        send_item(CMD_SNORM, 17'd0, 17'd777);

        // Unused family codes fall back to Zadeh
        set_family(FAM_SPARE_6);
        send_item(CMD_TNORM, 17'd100, 17'd200);
        set_family(FAM_SPARE_7);
        send_item(CMD_SNORM, 17'd100, 17'd200);

        // Random sets, one family each; one calm set and the last two without idling
        for (int k = 0; k < NUM_SETS; k++)
        begin
            set_family(set_family_code[k]);
            if (k == 3 || k >= NUM_SETS - 2)
            begin
                tx_gap_pct   = 0;
                rx_stall_pct = 0;
            end
            else
            begin
                tx_gap_pct   = $urandom_range(5, 40);
                rx_stall_pct = $urandom_range(5, 40);
            end
            for (int n = 0; n < ITEMS_PER_SET; n++)
            begin
                if ($urandom_range(0, 19) == 0)
                    c = CMD_SPARE;
                else
                    c = CMD_W'($urandom_range(0, 2));
                send_item(c, pick_grade(), pick_grade());
            end
        end

        wait_all_graded();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("fuzzy_norm_unit: match");
        else
        begin
            if (sb.pending.size() != 0)
                $display("%0t %0d expected grades never arrived", $time, sb.pending.size());
            $display("fuzzy_norm_unit: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
